[rtl/core/scba_pkg.sv]
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and constants for the size class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

   localparam int unsigned MAX_BLOCKS_DEF      = 1024;
   localparam int unsigned BLOCKS_PER_POOL_DEF = 16;
   localparam int unsigned MAX_CLASSES_DEF     = 16;

   localparam logic [1:0] OP_ALLOC  = 2'd0;
   localparam logic [1:0] OP_FREE   = 2'd1;
   localparam logic [1:0] OP_RESIZE = 2'd2;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOBLK   = 3'd1;
   localparam logic [2:0] ST_DOUBLE  = 3'd2;
   localparam logic [2:0] ST_INVALID = 3'd3;
   localparam logic [2:0] ST_LIMIT   = 3'd4;

   localparam logic [1:0] BS_NEVER = 2'd0;
   localparam logic [1:0] BS_FREE  = 2'd1;
   localparam logic [1:0] BS_USED  = 2'd2;

   localparam logic [1:0] CSR_MIN  = 2'd0;
   localparam logic [1:0] CSR_MAX  = 2'd1;
   localparam logic [1:0] CSR_MULT = 2'd2;

   // class search request / answer between the top level and the class unit
   typedef struct packed {
      logic        start;
      logic [31:0] size;
   } cls_req_type;

   typedef struct packed {
      logic       done;
      logic [4:0] cls;
   } cls_rsp_type;

endpackage

[rtl/core/scba_class_unit.sv]
// ----------------------------------------------------------------------------
// scba_class_unit
// Iterative size to class search: one multiply and compare per cycle.
// ----------------------------------------------------------------------------
module scba_class_unit #(
   parameter int unsigned MAX_CLASSES = scba_pkg::MAX_CLASSES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           min_size,
   input  logic [20:0]           max_size,
   input  logic [4:0]            mult,
   input  scba_pkg::cls_req_type req,
   output scba_pkg::cls_rsp_type rsp
);
   import scba_pkg::*;

   localparam int unsigned NW = $clog2(MAX_CLASSES + 1);

   logic          busy_ff, busy_in;
   logic [31:0]   size_ff, size_in;
   // bs is capped: once above max it only needs to stay above max
   logic [21:0]   bs_ff, bs_in;
   logic [NW-1:0] n_ff, n_in;
   logic          done_ff, done_in;
   logic [4:0]    cls_ff, cls_in;
   logic [26:0]   prod;
   logic          more;

   assign prod = bs_ff * mult;
   assign more = (n_ff < NW'(MAX_CLASSES)) && ({1'b0, bs_ff} <= {2'b0, max_size});

   always_comb begin
      busy_in = busy_ff;
      size_in = size_ff;
      bs_in   = bs_ff;
      n_in    = n_ff;
      done_in = 1'b0;
      cls_in  = cls_ff;
      if (req.start) begin
         busy_in = 1'b1;
         size_in = req.size;
         bs_in   = {6'd0, min_size};
         n_in    = '0;
      end else if (busy_ff) begin
         if (more && (size_ff <= {10'd0, bs_ff})) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cls_in  = 5'(n_ff);
         end else if (more) begin
            n_in  = n_ff + 1'b1;
            bs_in = (prod > 27'h200000) ? 22'h200001 : prod[21:0];
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cls_in  = (n_ff == '0) ? 5'd0 : 5'(n_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      size_ff <= size_in;
      bs_ff   <= bs_in;
      n_ff    <= n_in;
      cls_ff  <= cls_in;
   end

   assign rsp.done = done_ff;
   assign rsp.cls  = cls_ff;

endmodule

[rtl/core/size_class_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// Segregated free list block allocator with handle based block store.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel carries one request word (opcode, request_size, block_handle);
//  rsp_ channel returns one result word per request. Both use valid/stall.
//  csr_ channel writes min/max block size and the size multiplier; write
//  only while idle.
//  One request is handled at a time; req_stall is high while busy.
//  A valid free passes through the states RDH, CHK, REL and OUT; allocate and
//  resize also run the class search (one multiply-compare per cycle in
//  the class unit), and when a pool is carved BLOCKS_PER_POOL blocks are
//  written, one block per cycle through the block memories.
//  After reset a clearing pass walks the status memory, during which no
//  request is taken.
//  A result waits in the output register while rsp_stall is high; the
//  next request is taken only once it has gone.
// ----------------------------------------------------------------------------
module size_class_block_allocator_unit #(
   parameter int unsigned MAX_BLOCKS      = scba_pkg::MAX_BLOCKS_DEF,
   parameter int unsigned BLOCKS_PER_POOL = scba_pkg::BLOCKS_PER_POOL_DEF,
   parameter int unsigned MAX_CLASSES     = scba_pkg::MAX_CLASSES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_request_size,
   input  logic [9:0]  req_block_handle,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [9:0]  rsp_result_handle,
   output logic [3:0]  rsp_size_class,
   output logic        rsp_pool_created,
   output logic [6:0]  rsp_pools_total,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import scba_pkg::*;

   localparam int unsigned AW = $clog2(MAX_BLOCKS);
   localparam int unsigned CW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
   localparam int unsigned PW = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_RDH    = 11'b00000000100,
      S_CHK    = 11'b00000001000,
      S_CLS    = 11'b00000010000,
      S_GRAB   = 11'b00000100000,
      S_CARVE  = 11'b00001000000,
      S_POP    = 11'b00010000000,
      S_POPW   = 11'b00100000000,
      S_REL    = 11'b01000000000,
      S_OUT    = 11'b10000000000
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [15:0] min_ff;
   logic [20:0] max_ff;
   logic [4:0]  mult_ff;

   // block memories
   logic [1:0]    mem_st   [MAX_BLOCKS];
   logic [CW-1:0] mem_cls  [MAX_BLOCKS];
   logic [AW:0]   mem_link [MAX_BLOCKS];

   // head table: MAX_CLASSES entries, valid bits for empty at reset
   logic [AW-1:0] head_ff [MAX_CLASSES];
   logic [MAX_CLASSES-1:0] hvld_ff;

   logic [AW:0]   next_ff;
   logic [6:0]    pools_ff;

   // request word
   logic [1:0]    op_ff;
   logic [31:0]   size_ff;
   logic [9:0]    hin_ff;

   // handles widened so the address slice holds for any store depth
   logic [AW+9:0] hin_x, rqh_x;

   // read data
   logic [1:0]    rd_st;
   logic [CW-1:0] rd_cls;
   logic [AW:0]   rd_link;

   logic [AW-1:0] raddr;
   logic [AW-1:0] clr_ff;
   logic [PW-1:0] cnt_ff;
   logic [CW-1:0] c_ff;
   logic [AW-1:0] gh_ff;
   logic          carved_ff;

   logic          rv_ff;
   logic [2:0]    o_st_ff;
   logic [9:0]    o_h_ff;
   logic [3:0]    o_c_ff;

   cls_req_type creq;
   cls_rsp_type crsp;

   scba_class_unit #(.MAX_CLASSES(MAX_CLASSES)) u_cls (
      .clock(clock), .reset(reset), .min_size(min_ff), .max_size(max_ff),
      .mult(mult_ff), .req(creq), .rsp(crsp)
   );

   logic req_acc, hvalid;
   assign req_stall = (state_ff != S_IDLE) || rv_ff;
   assign req_acc   = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign hvalid    = {22'd0, hin_ff} < 32'(MAX_BLOCKS);
   assign hin_x     = {{AW{1'b0}}, hin_ff};
   assign rqh_x     = {{AW{1'b0}}, req_block_handle};

   assign creq.start = (state_ff == S_CHK) && (op_ff != OP_FREE);
   assign creq.size  = size_ff;

   // memory write port driven by the sequencer
   logic          we;
   logic [AW-1:0] waddr;
   logic [1:0]    wst;
   logic          wcls_en, wlink_en;
   logic [CW-1:0] wcls;
   logic [AW:0]   wlink;

   logic [CW-1:0] cur_cls;
   logic          cur_head_vld;
   logic [AW-1:0] cur_head;
   logic [AW:0]   carve_b;
   logic          full;

   assign cur_head_vld = hvld_ff[c_ff];
   assign cur_head     = head_ff[c_ff];
   assign carve_b      = next_ff + (AW+1)'(cnt_ff);
   assign full = ({1'b0, next_ff} + (AW+2)'(BLOCKS_PER_POOL)) > (AW+2)'(MAX_BLOCKS);

   always_comb begin
      raddr = hin_x[AW-1:0];
      unique case (state_ff)
         S_IDLE:  raddr = rqh_x[AW-1:0];
         S_POP:   raddr = cur_head;
         default: raddr = hin_x[AW-1:0];
      endcase
   end

   always_ff @(posedge clock) begin
      rd_st   <= mem_st[raddr];
      rd_cls  <= mem_cls[raddr];
      rd_link <= mem_link[raddr];
      if (we) mem_st[waddr] <= wst;
      if (wcls_en) mem_cls[waddr] <= wcls;
      if (wlink_en) mem_link[waddr] <= wlink;
   end

   always_comb begin
      state_in = state_ff;
      we = 1'b0; wcls_en = 1'b0; wlink_en = 1'b0;
      waddr = hin_x[AW-1:0]; wst = BS_FREE; wcls = rd_cls;
      wlink = {~cur_head_vld, cur_head};
      unique case (state_ff)
         S_CLEAR: begin
            we = 1'b1; waddr = clr_ff; wst = BS_NEVER;
            if (clr_ff == AW'(MAX_BLOCKS - 1)) state_in = S_IDLE;
         end
         S_IDLE:  if (req_acc) state_in = S_RDH;
         S_RDH:   state_in = S_CHK;
         S_CHK: begin
            if (op_ff == OP_ALLOC)
               state_in = ({11'd0, max_ff} < size_ff) ? S_OUT : S_CLS;
            else if (op_ff == OP_FREE)
               state_in = (!hvalid || rd_st != BS_USED) ? S_OUT : S_REL;
            else if (op_ff == OP_RESIZE)
               state_in = (!hvalid || rd_st != BS_USED ||
                           {11'd0, max_ff} < size_ff) ? S_OUT : S_CLS;
            else state_in = S_OUT;
         end
         S_CLS: if (crsp.done) begin
            if (op_ff == OP_RESIZE && crsp.cls <= 5'(rd_cls)) state_in = S_OUT;
            else state_in = S_GRAB;
         end
         S_GRAB: begin
            if (cur_head_vld) state_in = S_POP;
            else if (full) state_in = S_OUT;
            else state_in = S_CARVE;
         end
         S_CARVE: begin
            we = 1'b1; wcls_en = 1'b1; wlink_en = 1'b1;
            waddr = carve_b[AW-1:0]; wst = BS_FREE; wcls = c_ff;
            if (cnt_ff == PW'(BLOCKS_PER_POOL - 1)) state_in = S_POP;
         end
         S_POP: state_in = S_POPW;
         S_POPW: begin
            we = 1'b1; waddr = cur_head; wst = BS_USED;
            state_in = (op_ff == OP_RESIZE) ? S_REL : S_OUT;
         end
         S_REL: begin
            we = 1'b1; wlink_en = 1'b1; waddr = hin_x[AW-1:0]; wst = BS_FREE;
            wlink = {~hvld_ff[rd_cls], head_ff[rd_cls]};
            state_in = S_OUT;
         end
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign cur_cls = c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         hvld_ff  <= '0;
         next_ff  <= '0;
         pools_ff <= '0;
         rv_ff    <= 1'b0;
         min_ff   <= 16'd16;
         max_ff   <= 21'd1024;
         mult_ff  <= 5'd2;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_MIN:  min_ff  <= csr_data[15:0];
               CSR_MAX:  max_ff  <= csr_data[20:0];
               CSR_MULT: mult_ff <= csr_data[4:0];
               default: ;
            endcase
         end
         if (state_ff == S_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (rv_ff && !rsp_stall) rv_ff <= 1'b0;
         if (state_ff == S_CARVE) begin
            hvld_ff[cur_cls] <= 1'b1;
            head_ff[cur_cls] <= carve_b[AW-1:0];
            if (cnt_ff == PW'(BLOCKS_PER_POOL - 1)) begin
               next_ff <= next_ff + (AW+1)'(BLOCKS_PER_POOL);
               if (pools_ff != 7'd127) pools_ff <= pools_ff + 1'b1;
            end
         end
         if (state_ff == S_POPW) begin
            hvld_ff[cur_cls] <= ~rd_link[AW];
            head_ff[cur_cls] <= rd_link[AW-1:0];
         end
         if (state_ff == S_REL) begin
            hvld_ff[rd_cls] <= 1'b1;
            head_ff[rd_cls] <= hin_x[AW-1:0];
         end
         if (state_ff == S_OUT) rv_ff <= 1'b1;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         op_ff   <= req_opcode;
         size_ff <= req_request_size;
         hin_ff  <= req_block_handle;
      end
      unique case (state_ff)
         S_RDH: begin
            o_st_ff   <= ST_OK;
            o_h_ff    <= '0;
            o_c_ff    <= '0;
            carved_ff <= 1'b0;
            cnt_ff    <= '0;
         end
         S_CHK: begin
            if (op_ff == OP_ALLOC) begin
               if ({11'd0, max_ff} < size_ff) o_st_ff <= ST_LIMIT;
            end else if (op_ff == OP_FREE) begin
               if (!hvalid || rd_st == BS_NEVER) o_st_ff <= ST_INVALID;
               else if (rd_st == BS_FREE) o_st_ff <= ST_DOUBLE;
               else o_c_ff <= 4'(rd_cls);
            end else if (op_ff == OP_RESIZE) begin
               if (!hvalid || rd_st != BS_USED) o_st_ff <= ST_INVALID;
               else if ({11'd0, max_ff} < size_ff) o_st_ff <= ST_LIMIT;
            end else o_st_ff <= ST_INVALID;
         end
         S_CLS: if (crsp.done) begin
            c_ff <= CW'(crsp.cls);
            if (op_ff == OP_RESIZE && crsp.cls <= 5'(rd_cls)) begin
               o_h_ff <= hin_ff;
               o_c_ff <= 4'(rd_cls);
            end
         end
         S_GRAB: if (!cur_head_vld && full) o_st_ff <= ST_NOBLK;
         S_CARVE: begin
            cnt_ff    <= cnt_ff + 1'b1;
            carved_ff <= 1'b1;
         end
         S_POP: gh_ff <= cur_head;
         S_POPW: begin
            o_h_ff <= 10'(gh_ff);
            o_c_ff <= 4'(c_ff);
         end
         default: ;
      endcase
   end

   assign rsp_valid         = rv_ff;
   assign rsp_status        = o_st_ff;
   assign rsp_result_handle = o_h_ff;
   assign rsp_size_class    = o_c_ff;
   assign rsp_pool_created  = carved_ff;
   assign rsp_pools_total   = pools_ff;

endmodule
